/* design/mmh_pkg.sv */
package mmh_pkg;

   localparam logic [31:0] MIX_C1   = 32'hcc9e2d51;
   localparam logic [31:0] MIX_C2   = 32'h1b873593;
   localparam logic [31:0] FOLD_ADD = 32'he6546b64;
   localparam logic [31:0] FIN_M1   = 32'h85ebca6b;
   localparam logic [31:0] FIN_M2   = 32'hc2b2ae35;
   localparam logic [31:0] SEED_RESET = 32'd42;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = QUEUE_PTR_W + 1;

   localparam logic [2:0] FULL_CHUNK_BYTES = 3'd4;

   typedef enum logic [1:0] {
      KIND_FOLD,
      KIND_TAIL,
      KIND_NONE
   } mmh_kind_type;

   typedef struct packed {
      logic [31:0]  k1;
      mmh_kind_type kind;
      logic [2:0]   nbytes;
      logic         last;
   } mmh_entry_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MIX,
      ST_APPLY,
      ST_FIN1,
      ST_FIN2,
      ST_OUT
   } mmh_state_type;

endpackage

/* design/murmur3_32_stream_hash_top.sv */
// channel   direction  handshake                  payload
// req       in         req_valid / req_stall      req_chunk[31:0] req_valid_bytes[2:0] req_last
// rsp       out        rsp_valid / rsp_stall      rsp_hash[31:0]
// csr       in         csr_wr_en                  csr_wr_data[31:0] (seed)
//
// A request enters a 4-deep queue in the cycle it is accepted; the first mix multiply
// is done on the way in. The back end steps each non-last request through pop, second
// mix multiply and fold; a last request adds the two finalizer multiplies and the output load.
// The sequencer takes no new request until it is done with the last, which bounds the rate.
// Synchronous reset clears the queue, the sequencer and the output; the seed returns to 42.
// req_stall rises only when the queue is full; a stalled result holds in the output
// register while the back end goes on with the next request.
module murmur3_32_stream_hash_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_chunk,
   input  logic [2:0]  req_valid_bytes,
   input  logic        req_last,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_hash,
   input  logic        csr_wr_en,
   input  logic [31:0] csr_wr_data
);
   import mmh_pkg::*;

   mmh_entry_type push_entry;
   mmh_entry_type head;
   logic          push;
   logic          pop;
   logic          full;
   logic          not_empty;

   mmh_front u_front (
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_chunk       (req_chunk),
      .req_valid_bytes (req_valid_bytes),
      .req_last        (req_last),
      .queue_full      (full),
      .push            (push),
      .entry           (push_entry)
   );

   mmh_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (full),
      .pop        (pop),
      .not_empty  (not_empty),
      .head       (head)
   );

   mmh_back u_back (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .q_valid     (not_empty),
      .q_head      (head),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_hash    (rsp_hash)
   );

endmodule

/* design/mmh_front.sv */
module mmh_front (
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [31:0]            req_chunk,
   input  logic [2:0]             req_valid_bytes,
   input  logic                   req_last,
   input  logic                   queue_full,
   output logic                   push,
   output mmh_pkg::mmh_entry_type entry
);
   import mmh_pkg::*;

   logic [2:0]  vb_sat;
   logic [31:0] mask;
   logic [31:0] masked;

   // saturate byte count; only the last request honors it
   assign vb_sat = (req_valid_bytes > FULL_CHUNK_BYTES) ? FULL_CHUNK_BYTES : req_valid_bytes;

   always_comb begin
      mask = 32'hffffffff;
      if (req_last) begin
         unique case (vb_sat)
            3'd1:    mask = 32'h000000ff;
            3'd2:    mask = 32'h0000ffff;
            3'd3:    mask = 32'h00ffffff;
            default: mask = 32'hffffffff;
         endcase
      end
   end

   assign masked = req_chunk & mask;

   always_comb begin
      entry.k1     = masked * MIX_C1;
      entry.last   = req_last;
      entry.nbytes = req_last ? vb_sat : FULL_CHUNK_BYTES;
      priority if (!req_last || vb_sat == FULL_CHUNK_BYTES) begin
         entry.kind = KIND_FOLD;
      end else if (vb_sat == 3'd0) begin
         entry.kind = KIND_NONE;
      end else begin
         entry.kind = KIND_TAIL;
      end
   end

   assign req_stall = queue_full;
   assign push      = req_valid && !queue_full;

endmodule

/* design/mmh_queue.sv */
module mmh_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  mmh_pkg::mmh_entry_type push_entry,
   output logic                   full,
   input  logic                   pop,
   output logic                   not_empty,
   output mmh_pkg::mmh_entry_type head
);
   import mmh_pkg::*;

   mmh_entry_type              slot_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0]     count_ff, count_in;

   assign full      = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head      = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? QUEUE_PTR_W'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = pop  ? QUEUE_PTR_W'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = QUEUE_CNT_W'(count_ff + 1'b1);
      end else if (pop && !push) begin
         count_in = QUEUE_CNT_W'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QUEUE_CNT_W'(QUEUE_DEPTH))
      else $error("queue count above depth");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> not_empty)
      else $error("pop from empty queue");

   a_push_count: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> count_ff == QUEUE_CNT_W'($past(count_ff) + 1'b1))
      else $error("queue count lost a push");

endmodule

/* design/mmh_back.sv */
module mmh_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_wr_en,
   input  logic [31:0]            csr_wr_data,
   input  logic                   q_valid,
   input  mmh_pkg::mmh_entry_type q_head,
   output logic                   pop,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [31:0]            rsp_hash
);
   import mmh_pkg::*;

   mmh_state_type state_ff, state_in;
   logic          in_key_ff, in_key_in;
   logic [31:0]   seed_ff;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [31:0]   rsp_hash_ff, rsp_hash_in;
   logic [31:0]   hash_ff, hash_in;
   logic [31:0]   total_ff, total_in;
   logic [31:0]   k_ff, k_in;
   mmh_kind_type  kind_ff, kind_in;
   logic          last_ff, last_in;
   logic [31:0]   fin_ff, fin_in;

   logic          out_free;
   logic [31:0]   k_rot;
   logic [31:0]   k_mix;
   logic [31:0]   h_rot;
   logic [31:0]   h_fold;
   logic [31:0]   f0;
   logic [31:0]   f1;
   logic [31:0]   f2;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   assign k_rot  = {k_ff[16:0], k_ff[31:17]};
   assign k_mix  = k_rot * MIX_C2;
   assign h_rot  = {(hash_ff[18:0] ^ k_ff[18:0]), (hash_ff[31:19] ^ k_ff[31:19])};
   assign h_fold = (h_rot << 2) + h_rot + FOLD_ADD;
   assign f0     = hash_ff ^ total_ff;
   assign f1     = f0 ^ (f0 >> 16);
   assign f2     = fin_ff ^ (fin_ff >> 13);

   always_comb begin
      unique case (state_ff)
         ST_IDLE:  state_in = q_valid ? ST_MIX : ST_IDLE;
         ST_MIX:   state_in = ST_APPLY;
         ST_APPLY: state_in = last_ff ? ST_FIN1 : ST_IDLE;
         ST_FIN1:  state_in = ST_FIN2;
         ST_FIN2:  state_in = ST_OUT;
         ST_OUT:   state_in = out_free ? ST_IDLE : ST_OUT;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      pop          = 1'b0;
      in_key_in    = in_key_ff;
      hash_in      = hash_ff;
      total_in     = total_ff;
      k_in         = k_ff;
      kind_in      = kind_ff;
      last_in      = last_ff;
      fin_in       = fin_ff;
      rsp_hash_in  = rsp_hash_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               pop       = 1'b1;
               k_in      = q_head.k1;
               kind_in   = q_head.kind;
               last_in   = q_head.last;
               // first request of a key starts from the seed
               hash_in   = in_key_ff ? hash_ff : seed_ff;
               total_in  = (in_key_ff ? total_ff : 32'd0) + {29'd0, q_head.nbytes};
               in_key_in = 1'b1;
            end
         end
         ST_MIX: begin
            k_in = k_mix;
         end
         ST_APPLY: begin
            unique case (kind_ff)
               KIND_FOLD: hash_in = h_fold;
               KIND_TAIL: hash_in = hash_ff ^ k_ff;
               KIND_NONE: hash_in = hash_ff;
               default:   hash_in = hash_ff;
            endcase
         end
         ST_FIN1: begin
            fin_in    = f1 * FIN_M1;
            in_key_in = 1'b0;
         end
         ST_FIN2: begin
            fin_in = f2 * FIN_M2;
         end
         ST_OUT: begin
            if (out_free) begin
               rsp_hash_in  = fin_ff ^ (fin_ff >> 16);
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
            pop = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         in_key_ff    <= 1'b0;
         seed_ff      <= SEED_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         in_key_ff    <= in_key_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            seed_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      hash_ff     <= hash_in;
      total_ff    <= total_in;
      k_ff        <= k_in;
      kind_ff     <= kind_in;
      last_ff     <= last_in;
      fin_ff      <= fin_in;
      rsp_hash_ff <= rsp_hash_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_hash  = rsp_hash_ff;

   a_key_closed: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_FIN1 |=> !in_key_ff)
      else $error("key still open after finalize");

   a_out_loads: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT && out_free) |=> rsp_valid_ff && state_ff == ST_IDLE)
      else $error("finished hash not loaded into output register");

endmodule

/* tb/sv/hash_check_pkg.sv */
`timescale 1ns / 100ps

package hash_check_pkg;

   class hash_scoreboard;

      localparam logic [31:0] CHUNK_MUL1 = 32'hcc9e2d51;
      localparam logic [31:0] CHUNK_MUL2 = 32'h1b873593;
      localparam logic [31:0] ROUND_ADD  = 32'he6546b64;
      localparam logic [31:0] AVAL_MUL1  = 32'h85ebca6b;
      localparam logic [31:0] AVAL_MUL2  = 32'hc2b2ae35;
      localparam logic [2:0]  WORD_BYTES = 3'd4;

      logic [31:0] seed_value = 32'd42;
      logic [31:0] hash_acc   = 32'd0;
      logic [31:0] key_bytes  = 32'd0;
      bit          key_open   = 1'b0;
      logic [31:0] hash_queue[$];
      int unsigned mismatches = 0;

      function automatic logic [31:0] rotl(logic [31:0] v, int s);
         return (v << s) | (v >> (32 - s));
      endfunction

      function automatic logic [31:0] scramble(logic [31:0] k);
         logic [31:0] t;
         t = k * CHUNK_MUL1;
         t = rotl(t, 15);
         return t * CHUNK_MUL2;
      endfunction

      function automatic logic [31:0] round(logic [31:0] h, logic [31:0] k);
         logic [31:0] t;
         t = rotl(h ^ scramble(k), 13);
         return t * 32'd5 + ROUND_ADD;
      endfunction

      function automatic logic [31:0] avalanche(logic [31:0] h);
         logic [31:0] t;
         t = h ^ (h >> 16);
         t = t * AVAL_MUL1;
         t = t ^ (t >> 13);
         t = t * AVAL_MUL2;
         return t ^ (t >> 16);
      endfunction

      function void set_seed(logic [31:0] v);
         seed_value = v;
      endfunction

      function int pending();
         return hash_queue.size();
      endfunction

      // Advance the running hash by one accepted request; queue a hash on the last one.
      function void note_request(logic [31:0] chunk, logic [2:0] nbytes, logic last);
         logic [2:0]  n;
         logic [31:0] mask;
         if (!key_open) begin
            hash_acc  = seed_value;
            key_bytes = 32'd0;
            key_open  = 1'b1;
         end
         if (!last) begin
            hash_acc  = round(hash_acc, chunk);
            key_bytes = key_bytes + 32'd4;
            return;
         end
         n = (nbytes > WORD_BYTES) ? WORD_BYTES : nbytes;
         if (n == WORD_BYTES) begin
            hash_acc = round(hash_acc, chunk);
         end else if (n != 3'd0) begin
            mask     = (32'h1 << (8 * n)) - 32'h1;
            hash_acc = hash_acc ^ scramble(chunk & mask);
         end
         key_bytes = key_bytes + {29'd0, n};
         hash_queue.push_back(avalanche(hash_acc ^ key_bytes));
         key_open  = 1'b0;
         hash_acc  = seed_value;
         key_bytes = 32'd0;
      endfunction

      function void check_hash(logic [31:0] actual);
         logic [31:0] want;
         if (hash_queue.size() == 0) begin
            $error("rsp_hash: expected no hash, got %08h", actual);
            mismatches++;
            return;
         end
         want = hash_queue.pop_front();
         if (actual !== want) begin
            $error("rsp_hash: expected %08h, got %08h", want, actual);
            mismatches++;
         end
      endfunction

   endclass

endpackage

/* tb/sv/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
   import hash_check_pkg::*;

   localparam int RESET_CYCLES     = 6;
   localparam int SETTLE_CYCLES    = 40;
   localparam int HOLD_CYCLES      = 300;
   localparam int IDLE_LIMIT       = 5000;
   localparam int DIRECTED_ITEMS   = 20;
   localparam int ITEMS_PER_PHASE  = 166;
   localparam int RANDOM_PHASES    = 5;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [31:0] req_chunk;
   logic [2:0]  req_valid_bytes;
   logic        req_last;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [31:0] rsp_hash;
   logic        csr_wr_en;
   logic [31:0] csr_wr_data;

   hash_scoreboard sb;
   bit             hold_rsp_req = 1'b0;
   bit             no_gaps = 1'b0;
   int             items_sent = 0;

   murmur3_32_stream_hash_top i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_chunk       (req_chunk),
      .req_valid_bytes (req_valid_bytes),
      .req_last        (req_last),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_hash        (rsp_hash),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data)
   );

   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [31:0] rand_chunk();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return 32'h0000_0000;
      if (r == 1) return 32'hffff_ffff;
      return $urandom;
   endfunction

   function automatic int pick_key_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return $urandom_range(0, 4);
      if (r < 95) return $urandom_range(5, 12);
      return $urandom_range(20, 40);
   endfunction

   // Offer one request and hold it until accepted; valid stays high afterwards.
   task automatic send_request(logic [31:0] chunk, logic [2:0] nbytes, logic last);
      int gap;
      gap = no_gaps ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_chunk       <= chunk;
      req_valid_bytes <= nbytes;
      req_last        <= last;
      do @(posedge clock); while (req_stall);
      sb.note_request(chunk, nbytes, last);
      items_sent++;
   endtask

   task automatic send_key(int body_words, logic [2:0] tail_bytes);
      logic [2:0] junk_bytes;
      repeat (body_words) begin
         junk_bytes = 3'($urandom_range(0, 7));
         send_request(rand_chunk(), junk_bytes, 1'b0);
      end
      send_request(rand_chunk(), tail_bytes, 1'b1);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   // Drained plus time for queued body requests that produce no hash.
   task automatic wait_idle();
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_seed(logic [31:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      sb.set_seed(value);
      @(posedge clock);
   endtask

   // Result side: random stall runs, quiet stretches, and a long hold on request.
   initial begin : rsp_side
      int stall_left;
      int free_left;
      stall_left = 0;
      free_left  = 0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) sb.check_hash(rsp_hash);
         if (hold_rsp_req) begin
            hold_rsp_req = 1'b0;
            stall_left   = HOLD_CYCLES;
            free_left    = 0;
         end else if (stall_left == 0 && free_left == 0) begin
            if ($urandom_range(0, 9) == 0) begin
               free_left = 80;
            end else begin
               free_left  = pick_gap() + 1;
               stall_left = pick_gap();
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else begin
            free_left--;
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin : watchdog
      int idle;
      idle = 0;
      while (idle < IDLE_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle = 0;
         else idle++;
      end
      $display("Some tests failed");
      $finish;
   end

   initial begin : stimulus
      int phase;
      logic [2:0]  tail_bytes;
      logic [31:0] seed_pick;
      sb = new();
      reset           <= 1'b1;
      req_valid       <= 1'b0;
      req_chunk       <= 32'd0;
      req_valid_bytes <= 3'd0;
      req_last        <= 1'b0;
      csr_wr_en       <= 1'b0;
      csr_wr_data     <= 32'd0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset seed: empty key, partial tails with junk above, full and oversized tails
      send_request(32'hdead_beef, 3'd0, 1'b1);
      send_request(32'hffff_ffff, 3'd1, 1'b1);
      send_request(32'hffff_ffff, 3'd2, 1'b1);
      send_request(32'hffff_ffff, 3'd3, 1'b1);
      send_request(32'hffff_ffff, 3'd4, 1'b1);
      send_request(32'h1234_5678, 3'd5, 1'b1);
      send_request(32'h8765_4321, 3'd6, 1'b1);
      send_request(32'hffff_ffff, 3'd7, 1'b1);
      // body requests ignore their byte count
      send_request(32'h0000_0000, 3'd0, 1'b0);
      send_request(32'hffff_ffff, 3'd7, 1'b0);
      send_request(32'h0000_0000, 3'd4, 1'b1);

      wait_idle();
      write_seed(32'h0000_0000);
      send_request(32'h8000_0001, 3'd2, 1'b0);
      send_request(32'h00ab_cdef, 3'd3, 1'b1);

      wait_idle();
      write_seed(32'hffff_ffff);
      send_request(32'h7fff_fffe, 3'd1, 1'b0);
      send_request(32'hffff_ffff, 3'd0, 1'b1);

      // seed changed with a key open: the old seed stays in force for that key
      send_request(32'hcafe_f00d, 3'd0, 1'b0);
      send_request(32'h0bad_c0de, 3'd4, 1'b0);
      wait_idle();
      write_seed(32'h1234_5678);
      send_request(32'h5555_aaaa, 3'd2, 1'b1);
      send_request(32'haaaa_5555, 3'd1, 1'b1);

      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         wait_idle();
         case (phase)
            1:       seed_pick = 32'hffff_ffff;
            2:       seed_pick = 32'h0000_0000;
            default: seed_pick = $urandom;
         endcase
         write_seed(seed_pick);
         if (phase == 1) begin
            // hold the result side and keep offering until the input stalls
            hold_rsp_req = 1'b1;
            no_gaps      = 1'b1;
            repeat (10) send_key($urandom_range(1, 4), 3'd4);
         end
         no_gaps = (phase == 3);
         while (items_sent < DIRECTED_ITEMS + (phase + 1) * ITEMS_PER_PHASE) begin
            tail_bytes = 3'($urandom_range(0, 7));
            send_key(pick_key_len(), tail_bytes);
            if ($urandom_range(0, 19) == 0) wait_drained();
         end
      end

      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
